>>> rtl/rbsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsa_pkg: shared definitions for the random bitmap slot allocator
// Field widths, operation and status codes, controller states and the
// reset value of the free-slot bitmap.
// ----------------------------------------------------------------------------
package rbsa_pkg;

  localparam int NUM_SLOTS = 32;
  localparam int SLOT_W    = 5;
  localparam int MASK_W    = 32;
  localparam int CNT_W     = 6;
  localparam int RND_W     = 32;
  localparam int STATUS_W  = 2;

  // Remainder digits retired per cycle by the divider.
  localparam int DIV_DIGIT = 2;
  localparam int DIV_STEPS = RND_W / DIV_DIGIT;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [MASK_W-1:0] RESET_MASK  = {MASK_W{1'b1}} >> (MASK_W - NUM_SLOTS);
  localparam logic [CNT_W-1:0]  RESET_COUNT = CNT_W'(NUM_SLOTS);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DOUBLE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_EMIT
  } state_t;

endpackage

>>> rtl/rbsa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsa_if: request and result channels of the slot allocator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rbsa_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [rbsa_pkg::SLOT_W-1:0]   slot_to_free;
  logic [rbsa_pkg::RND_W-1:0]    random_value;

  modport source (output valid, operation, slot_to_free, random_value, input ready);
  modport sink   (input valid, operation, slot_to_free, random_value, output ready);
endinterface

interface rbsa_out_if;
  logic                          valid;
  logic                          ready;
  logic [rbsa_pkg::SLOT_W-1:0]   granted_slot;
  logic [rbsa_pkg::STATUS_W-1:0] status;
  logic [rbsa_pkg::CNT_W-1:0]    free_count;

  modport source (output valid, granted_slot, status, free_count, input ready);
  modport sink   (input valid, granted_slot, status, free_count, output ready);
endinterface

>>> rtl/random_bitmap_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_bitmap_slot_allocator: free-slot bitmap with random choice
// Allocates the slot whose rank among the free slots is the random value
// modulo the free count; returns slots and flags double frees.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per beat: operation (0 allocate, 1 free),
//   slot_to_free and random_value. out_ch returns exactly one result beat
//   per request: granted_slot, status and the free count after the request.
//   One request is worked on at a time; in_ch.ready is high while idle.
//   Free requests and allocations on a full bitmap go from idle straight to
//   the emit state and then into the output register. An allocation runs a
//   remainder divider that retires two bits of random_value per cycle, then
//   a bit-serial rank scan over the bitmap; the scan length is set by the
//   granted slot.
//   A full bitmap is reported with status 1 and never blocks.
//   Reset (rst_n low, synchronous) marks every slot free and empties the
//   output register. A stalled receiver holds the result in the output
//   register; the block may take the next request and finish it, and then
//   waits until the output register is free.
// ----------------------------------------------------------------------------
module random_bitmap_slot_allocator (
  input  logic              clk,
  input  logic              rst_n,
  rbsa_in_if.sink           in_ch,
  rbsa_out_if.source        out_ch
);

  rbsa_pkg::state_t state_r, state_nxt;

  logic [rbsa_pkg::MASK_W-1:0]   mask_r, mask_nxt;
  logic [rbsa_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [rbsa_pkg::RND_W-1:0]    dvd_r, dvd_nxt;
  logic [rbsa_pkg::CNT_W-1:0]    rem_r, rem_nxt;
  logic [rbsa_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [rbsa_pkg::MASK_W-1:0]   scan_r, scan_nxt;
  logic [rbsa_pkg::SLOT_W-1:0]   idx_r, idx_nxt;
  logic [rbsa_pkg::SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [rbsa_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [rbsa_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [rbsa_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [rbsa_pkg::CNT_W-1:0]    out_count_r, out_count_nxt;

  logic in_fire;
  logic emit_fire;
  logic div_done;
  logic scan_hit;
  logic start_div;

  localparam logic [rbsa_pkg::STEP_W-1:0] DIV_LAST = rbsa_pkg::STEP_W'(rbsa_pkg::DIV_STEPS - 1);
  localparam logic [rbsa_pkg::CNT_W-1:0]  SLOT_LIMIT = rbsa_pkg::CNT_W'(rbsa_pkg::NUM_SLOTS);

  // ---------------- control outputs ----------------
  always_comb begin
    in_ch.ready = (state_r == rbsa_pkg::S_IDLE);
    in_fire     = in_ch.valid && (state_r == rbsa_pkg::S_IDLE);
    emit_fire   = (state_r == rbsa_pkg::S_EMIT) && (!out_valid_r || out_ch.ready);
    div_done    = (state_r == rbsa_pkg::S_DIV) && (step_r == DIV_LAST);
    scan_hit    = (state_r == rbsa_pkg::S_SCAN) && scan_r[0] && (rem_r == '0);
    start_div   = in_fire && (in_ch.operation == rbsa_pkg::OP_ALLOC) && (cnt_r != '0);
  end

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rbsa_pkg::S_IDLE: begin
        if (start_div) begin
          state_nxt = rbsa_pkg::S_DIV;
        end else if (in_fire) begin
          state_nxt = rbsa_pkg::S_EMIT;
        end
      end
      rbsa_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = rbsa_pkg::S_SCAN;
        end
      end
      rbsa_pkg::S_SCAN: begin
        if (scan_hit) begin
          state_nxt = rbsa_pkg::S_EMIT;
        end
      end
      rbsa_pkg::S_EMIT: begin
        if (emit_fire) begin
          state_nxt = rbsa_pkg::S_IDLE;
        end
      end
      default: state_nxt = rbsa_pkg::S_IDLE;
    endcase
  end

  // ---------------- datapath ----------------
  always_comb begin
    logic [rbsa_pkg::CNT_W:0] part1;
    logic [rbsa_pkg::CNT_W:0] part2;
    logic [rbsa_pkg::CNT_W:0] divisor;

    mask_nxt       = mask_r;
    cnt_nxt        = cnt_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    step_nxt       = step_r;
    scan_nxt       = scan_r;
    idx_nxt        = idx_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;

    // Two restoring remainder steps per cycle; the partial remainder stays
    // below the free count, so seven bits hold the shifted value.
    divisor = {1'b0, cnt_r};
    part1   = {rem_r, dvd_r[rbsa_pkg::RND_W-1]};
    if (part1 >= divisor) begin
      part1 = part1 - divisor;
    end
    part2 = {part1[rbsa_pkg::CNT_W-1:0], dvd_r[rbsa_pkg::RND_W-2]};
    if (part2 >= divisor) begin
      part2 = part2 - divisor;
    end

    if (in_fire) begin
      res_slot_nxt   = '0;
      res_status_nxt = rbsa_pkg::ST_OK;
      if (in_ch.operation == rbsa_pkg::OP_FREE) begin
        if ({1'b0, in_ch.slot_to_free} < SLOT_LIMIT) begin
          if (mask_r[in_ch.slot_to_free]) begin
            res_status_nxt = rbsa_pkg::ST_DOUBLE;
          end else begin
            mask_nxt[in_ch.slot_to_free] = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end else if (cnt_r == '0) begin
        res_status_nxt = rbsa_pkg::ST_FULL;
      end else begin
        dvd_nxt  = in_ch.random_value;
        rem_nxt  = '0;
        step_nxt = '0;
      end
    end

    if (state_r == rbsa_pkg::S_DIV) begin
      rem_nxt  = part2[rbsa_pkg::CNT_W-1:0];
      dvd_nxt  = {dvd_r[rbsa_pkg::RND_W-3:0], 2'b00};
      step_nxt = step_r + 1'b1;
      if (div_done) begin
        scan_nxt = mask_r;
        idx_nxt  = '0;
      end
    end

    // The remainder is the rank still to skip; each free slot passed
    // counts it down until the wanted one sits in the low bit.
    if (state_r == rbsa_pkg::S_SCAN) begin
      scan_nxt = scan_r >> 1;
      idx_nxt  = idx_r + 1'b1;
      if (scan_hit) begin
        mask_nxt[idx_r] = 1'b0;
        cnt_nxt         = cnt_r - 1'b1;
        res_slot_nxt    = idx_r;
        res_status_nxt  = rbsa_pkg::ST_OK;
      end else if (scan_r[0]) begin
        rem_nxt = rem_r - 1'b1;
      end
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    if (emit_fire) begin
      out_valid_nxt  = 1'b1;
      out_slot_nxt   = res_slot_r;
      out_status_nxt = res_status_r;
      out_count_nxt  = cnt_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.granted_slot = out_slot_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.free_count   = out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rbsa_pkg::S_IDLE;
      mask_r      <= rbsa_pkg::RESET_MASK;
      cnt_r       <= rbsa_pkg::RESET_COUNT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    step_r       <= step_nxt;
    scan_r       <= scan_nxt;
    idx_r        <= idx_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

>>> dv/slot_alloc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_alloc_checker: result predictor and comparator for the slot allocator
// Watches the request and result channels. Every accepted request beat
// updates a private copy of the free-slot bitmap and queues the expected
// result. Every accepted result beat is compared with the oldest one.
// ----------------------------------------------------------------------------
module slot_alloc_checker (
  input  logic        clk,
  input  logic        rst_n,
  rbsa_in_if          in_ch,
  rbsa_out_if         out_ch,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    logic [rbsa_pkg::SLOT_W-1:0]   granted_slot;
    logic [rbsa_pkg::STATUS_W-1:0] status;
    logic [rbsa_pkg::CNT_W-1:0]    free_count;
  } alloc_result_t;

  logic [rbsa_pkg::MASK_W-1:0] free_bitmap;
  alloc_result_t               expected_results[$];
  int unsigned                 mismatches;

  assign fail_count = mismatches;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic logic [rbsa_pkg::CNT_W-1:0] count_free(
      logic [rbsa_pkg::MASK_W-1:0] bitmap);
    logic [rbsa_pkg::CNT_W-1:0] total;
    total = '0;
    for (int i = 0; i < rbsa_pkg::MASK_W; i++) total += rbsa_pkg::CNT_W'(bitmap[i]);
    return total;
  endfunction

  // Applies one request to the bitmap copy and returns the result it yields.
  function automatic alloc_result_t predict_request(logic op,
                                                    logic [rbsa_pkg::SLOT_W-1:0] slot,
                                                    logic [rbsa_pkg::RND_W-1:0] rnd);
    alloc_result_t              res;
    logic [rbsa_pkg::CNT_W-1:0] avail;
    logic [rbsa_pkg::RND_W-1:0] rank;
    bit                         found;
    res    = '0;
    found  = 1'b0;
    res.status = rbsa_pkg::ST_OK;
    if (op == rbsa_pkg::OP_ALLOC) begin
      avail = count_free(free_bitmap);
      if (avail == '0) begin
        res.status = rbsa_pkg::ST_FULL;
      end else begin
        rank = rnd % rbsa_pkg::RND_W'(avail);
        // Walk the set bits from bit 0 until the rank runs out.
        for (int i = 0; i < rbsa_pkg::MASK_W; i++) begin
          if (!found && free_bitmap[i]) begin
            if (rank == '0) begin
              res.granted_slot = rbsa_pkg::SLOT_W'(i);
              found = 1'b1;
            end else begin
              rank--;
            end
          end
        end
        free_bitmap[res.granted_slot] = 1'b0;
      end
    end else if (int'(slot) < rbsa_pkg::NUM_SLOTS) begin
      if (free_bitmap[slot]) res.status = rbsa_pkg::ST_DOUBLE;
      else free_bitmap[slot] = 1'b1;
    end
    res.free_count = count_free(free_bitmap);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    alloc_result_t got;
    alloc_result_t want;
    if (!rst_n) begin
      free_bitmap = rbsa_pkg::RESET_MASK;
      expected_results.delete();
    end else begin
      // A result can never belong to a request taken at the same edge.
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.granted_slot, out_ch.status, out_ch.free_count};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat: slot %0d status %0d count %0d",
                   $time, got.granted_slot, got.status, got.free_count);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: exp slot %0d st %0d cnt %0d, got slot %0d st %0d cnt %0d",
                     $time, want.granted_slot, want.status, want.free_count,
                     got.granted_slot, got.status, got.free_count);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(predict_request(in_ch.operation, in_ch.slot_to_free,
                                                   in_ch.random_value));
    end
    pending <= expected_results.size();
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the random bitmap slot allocator
// Sends a short directed sequence and then bursts of allocations, frees and
// mixed requests with random gaps and result stalls, including one long
// result stall that backs up the request channel. Checking is done by
// slot_alloc_checker.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          RANDOM_ITEMS = 2000;
  localparam int          LONG_STALL   = 400;
  localparam int          TAIL_CYCLES  = 60;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count;
  int unsigned items_sent;
  bit          sender_gaps;
  bit          sink_hold;

  rbsa_in_if  in_ch ();
  rbsa_out_if out_ch ();

  random_bitmap_slot_allocator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  slot_alloc_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: after each beat, stall for a drawn number of cycles, with
  // regular stretches of no stalls; one long stall on request.
  initial begin : result_sink
    int unsigned stall;
    int unsigned beats;
    beats = 0;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    @(negedge clk);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      stall = 0;
      if (sink_hold) begin
        sink_hold = 1'b0;
        stall = LONG_STALL;
      end else if (out_ch.valid && out_ch.ready) begin
        beats++;
        stall = ((beats / 128) % 4 == 3) ? 0 : $urandom_range(0, 6);
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
        @(negedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [rbsa_pkg::RND_W-1:0] draw_random_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return rbsa_pkg::RND_W'($urandom_range(0, 40));
      default: return rbsa_pkg::RND_W'($urandom);
    endcase
  endfunction

  // Offers one request beat and returns at the edge where it is taken.
  // valid stays high afterwards so back-to-back beats need no extra step.
  task automatic send_request(logic op, logic [rbsa_pkg::SLOT_W-1:0] slot,
                              logic [rbsa_pkg::RND_W-1:0] rnd);
    int unsigned gap;
    gap = sender_gaps ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid        <= 1'b0;
      in_ch.operation    <= 1'($urandom);
      in_ch.slot_to_free <= rbsa_pkg::SLOT_W'($urandom);
      in_ch.random_value <= rbsa_pkg::RND_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.slot_to_free <= slot;
    in_ch.random_value <= rnd;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic run_burst(int unsigned kind);
    int unsigned len;
    logic        op;
    len = $urandom_range(10, 40);
    for (int unsigned i = 0; i < len; i++) begin
      case (kind)
        0:       op = rbsa_pkg::OP_ALLOC;
        1:       op = rbsa_pkg::OP_FREE;
        default: op = 1'($urandom);
      endcase
      send_request(op, rbsa_pkg::SLOT_W'($urandom_range(0, rbsa_pkg::NUM_SLOTS - 1)),
                   draw_random_value());
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = rbsa_pkg::OP_ALLOC;
    in_ch.slot_to_free = '0;
    in_ch.random_value = '0;
    sender_gaps        = 1'b1;
    sink_hold          = 1'b0;
    items_sent         = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: double frees on a fresh bitmap, extreme random values,
    // returning a granted slot, and a slot index that allocation ignores.
    send_request(rbsa_pkg::OP_FREE,  5'd0,  '0);
    send_request(rbsa_pkg::OP_FREE,  5'd31, '1);
    send_request(rbsa_pkg::OP_ALLOC, 5'd0,  '0);
    send_request(rbsa_pkg::OP_ALLOC, 5'd31, '1);
    send_request(rbsa_pkg::OP_ALLOC, 5'd21, 32'h8000_0000);
    send_request(rbsa_pkg::OP_ALLOC, 5'd10, 32'h5555_5555);
    send_request(rbsa_pkg::OP_ALLOC, 5'd0,  32'hAAAA_AAAA);
    send_request(rbsa_pkg::OP_FREE,  5'd0,  '1);
    send_request(rbsa_pkg::OP_FREE,  5'd0,  '0);
    send_request(rbsa_pkg::OP_FREE,  5'd31, 32'h0000_0001);
    send_request(rbsa_pkg::OP_FREE,  5'd16, '0);
    send_request(rbsa_pkg::OP_ALLOC, 5'd31, 32'd31);
    send_request(rbsa_pkg::OP_ALLOC, 5'd15, 32'd1);
    send_request(rbsa_pkg::OP_ALLOC, 5'd0,  32'hFFFF_FFFE);
    send_request(rbsa_pkg::OP_FREE,  5'd15, 32'hDEAD_BEEF);
    send_request(rbsa_pkg::OP_FREE,  5'd1,  '0);
    wait_for_results();

    // Long result stall while allocations keep coming: the block backs up,
    // and the bitmap runs full so the full status is seen as well.
    sender_gaps = 1'b0;
    @(negedge clk);
    sink_hold = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_request(rbsa_pkg::OP_ALLOC, rbsa_pkg::SLOT_W'($urandom), draw_random_value());
    end
    wait_for_results();

    while (items_sent < RANDOM_ITEMS) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2: run_burst(0);
        3, 4, 5: run_burst(1);
        6, 7, 8: run_burst(2);
        default: wait_for_results();
      endcase
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
